// ===== hw/rtl/oled_pkg.sv =====
// Shared types, constants and index helpers for the ordered list engine.
// Used by oled_ram, oled_cmp and ordered_list_engine_unit; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package oled_pkg;

  // List capacity and the widths that follow from it
  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SUM_W    = CNT_W + 1;

  // Field widths fixed by the stream format
  localparam int DATA_W      = 32;
  localparam int OP_W        = 2;
  localparam int ST_W        = 2;
  localparam int POS_W       = 7;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 80;

  // Operation codes
  localparam logic [OP_W-1:0] OP_FRONT  = 2'd0;
  localparam logic [OP_W-1:0] OP_BACK   = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [OP_W-1:0] OP_LOCATE = 2'd3;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_MISS = 2'd2;

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Store write request
  typedef struct packed {
    logic  en;
    idx_t  addr;
    data_t data;
  } ram_wr_t;

  // Running extremes fed to the compare unit
  typedef struct packed {
    logic  have;
    data_t max_v;
    data_t min_v;
  } acc_t;

  // Compare unit answer
  typedef struct packed {
    logic  eq;
    data_t max_v;
    data_t min_v;
  } cmp_res_t;

  // Physical slot of a logical position, wrapped round the circular store
  function automatic idx_t slot_of(input idx_t head, input cnt_t logical);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(logical);
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  // Slot in front of the head, wrapped
  function automatic idx_t slot_before(input idx_t head);
    idx_t r;
    if (head == '0) begin
      r = IDX_W'(CAPACITY - 1);
    end else begin
      r = head - IDX_W'(1);
    end
    return r;
  endfunction

  // Count or index masked to a 7-bit field
  function automatic logic [POS_W-1:0] to_field7(input cnt_t c);
    logic [31:0] t;
    t = 32'(c);
    return t[POS_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/oled_ram.sv =====
// Circular entry store: one write port and one registered read port.
// Depends on oled_pkg for the depth, widths and write request type.
`timescale 1ns / 1ps
`default_nettype none

module oled_ram (
  input  wire                     clk,
  input  wire oled_pkg::ram_wr_t  wr,
  input  wire oled_pkg::idx_t     rd_addr,
  output oled_pkg::data_t         rd_data
);
  import oled_pkg::*;

  data_t mem_r [CAPACITY];
  data_t rd_data_r;

  // Write the requested slot
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
  end

  // Register the read word
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/oled_cmp.sv =====
// Shared compare unit: key match and signed max/min update for one word.
// Depends on oled_pkg for the accumulator and result types.
`timescale 1ns / 1ps
`default_nettype none

module oled_cmp (
  input  wire oled_pkg::data_t    operand,
  input  wire oled_pkg::data_t    key,
  input  wire oled_pkg::acc_t     acc,
  output oled_pkg::cmp_res_t      res
);
  import oled_pkg::*;

  logic above;
  logic below;

  // Signed compares against the running extremes
  assign above = $signed(operand) > $signed(acc.max_v);
  assign below = $signed(operand) < $signed(acc.min_v);

  // Key match; take the word as the new extreme when none is held yet or it lies beyond the held one
  always_comb begin
    res.eq    = (operand == key);
    res.max_v = (!acc.have || above) ? operand : acc.max_v;
    res.min_v = (!acc.have || below) ? operand : acc.min_v;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ordered_list_engine_unit.sv =====
// Top level of the ordered list engine: sequencer, list registers, output word.
// Depends on oled_pkg, oled_ram and oled_cmp.
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | Ports                          | Contents
// in      | in  | in_tvalid/in_tready/in_tdata   | tuser: operation; tdata: value
// out     | out | out_tvalid/out_tready/out_tdata| tuser: status; tdata: results
//
// Insert: the write and the extreme update are made at accept; the result is loaded in S_POST.
// Remove and locate: the single store read port walks every held entry once,
// closing up the list behind a removed entry meanwhile.
// An empty-list remove or locate, or a full-list insert, goes straight to S_POST.
// in_tready is low while an item is in work or its result cannot be loaded.
// Reset empties the list; the store itself is not cleared.
module ordered_list_engine_unit (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // [31:0] value, [39:32] zero
  input  wire  [oled_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [1:0] operation
  input  wire  [oled_pkg::OP_W-1:0]         in_tuser,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // [6:0] position, [13:7] entry_count, [45:14] max_value, [77:46] min_value,
  // [79:78] zero
  output logic [oled_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // [1:0] status
  output logic [oled_pkg::ST_W-1:0]         out_tuser
);
  import oled_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_POST = 2'd2;

  logic [1:0]      state_r, state_nxt;
  idx_t            head_r, head_nxt;
  cnt_t            count_r, count_nxt;
  cnt_t            didx_r, didx_nxt;
  cnt_t            hit_r, hit_nxt;
  logic            found_r, found_nxt;
  logic [OP_W-1:0] op_r, op_nxt;
  data_t           key_r, key_nxt;
  acc_t            acc_r, acc_nxt;
  logic [ST_W-1:0] status_r, status_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;

  logic            out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [ST_W-1:0] out_user_r;
  logic            load_out;

  ram_wr_t         wr;
  idx_t            rd_addr;
  data_t           rd_data;
  data_t           cmp_operand;
  data_t           cmp_key;
  cmp_res_t        cmp_res;

  logic [OP_W-1:0] in_op;
  data_t           in_value;
  logic            hit_now;
  logic            last_word;
  logic            found_fin;
  cnt_t            hit_fin;
  data_t           res_max;
  data_t           res_min;

  assign in_op    = in_tuser;
  assign in_value = in_tdata[DATA_W-1:0];

  oled_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Feed the shared unit from the input word or the store read word
  assign cmp_operand = (state_r == S_SCAN) ? rd_data : in_value;
  assign cmp_key     = key_r;

  oled_cmp u_cmp (
    .operand (cmp_operand),
    .key     (cmp_key),
    .acc     (acc_r),
    .res     (cmp_res)
  );

  // Scan bookkeeping for the word now on the read port
  assign hit_now   = !found_r && cmp_res.eq;
  assign last_word = (didx_r == count_r - CNT_W'(1));
  assign found_fin = found_r || hit_now;
  assign hit_fin   = found_r ? hit_r : didx_r;

  assign in_tready = (state_r == S_IDLE);
  assign load_out  = (state_r == S_POST) && (!out_valid_r || out_tready);

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    didx_nxt   = didx_r;
    hit_nxt    = hit_r;
    found_nxt  = found_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    acc_nxt    = acc_r;
    status_nxt = status_r;
    pos_nxt    = pos_r;
    wr.en      = 1'b0;
    wr.addr    = slot_of(head_r, count_r);
    wr.data    = in_value;
    rd_addr    = slot_of(head_r, didx_r + CNT_W'(1));

    unique case (state_r)
      S_IDLE: begin
        rd_addr = head_r;
        if (in_tvalid) begin
          op_nxt     = in_op;
          key_nxt    = in_value;
          status_nxt = ST_OK;
          pos_nxt    = '1;
          didx_nxt   = '0;
          found_nxt  = 1'b0;
          state_nxt  = S_POST;
          if (in_op == OP_FRONT || in_op == OP_BACK) begin
            if (count_r == CNT_W'(CAPACITY)) begin
              status_nxt = ST_FULL;
            end else begin
              // Insert the word and fold it into the extremes
              wr.en = 1'b1;
              if (in_op == OP_FRONT) begin
                wr.addr  = slot_before(head_r);
                head_nxt = slot_before(head_r);
              end
              count_nxt     = count_r + CNT_W'(1);
              acc_nxt.have  = 1'b1;
              acc_nxt.max_v = cmp_res.max_v;
              acc_nxt.min_v = cmp_res.min_v;
            end
          end else if (count_r == '0) begin
            status_nxt = ST_MISS;
          end else begin
            // Start a walk from the front; rebuild the extremes on the way
            acc_nxt.have = 1'b0;
            state_nxt    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        didx_nxt = didx_r + CNT_W'(1);
        if (hit_now) begin
          found_nxt = 1'b1;
          hit_nxt   = didx_r;
        end
        // Drop the removed word from the extremes, keep all others
        if (!(hit_now && op_r == OP_REMOVE)) begin
          acc_nxt.have  = 1'b1;
          acc_nxt.max_v = cmp_res.max_v;
          acc_nxt.min_v = cmp_res.min_v;
        end
        // Close up behind a removed entry
        if (found_r && op_r == OP_REMOVE) begin
          wr.en   = 1'b1;
          wr.addr = slot_of(head_r, didx_r - CNT_W'(1));
          wr.data = rd_data;
        end
        if (last_word) begin
          state_nxt = S_POST;
          if (!found_fin) begin
            status_nxt = ST_MISS;
          end else if (op_r == OP_LOCATE) begin
            pos_nxt = to_field7(hit_fin);
          end else begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      S_POST: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      count_r      <= '0;
      acc_r        <= '0;
      found_r      <= 1'b0;
      didx_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      acc_r        <= acc_nxt;
      found_r      <= found_nxt;
      didx_r       <= didx_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    hit_r       <= hit_nxt;
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    status_r    <= status_nxt;
    pos_r       <= pos_nxt;
  end

  // Extremes read as all ones when the list is empty
  assign res_max = acc_r.have ? acc_r.max_v : '1;
  assign res_min = acc_r.have ? acc_r.min_v : '1;

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= {2'b00, res_min, res_max, to_field7(count_r), pos_r};
      out_user_r <= status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

// ===== dv/ordered_list_engine_unit_tb.sv =====
// Self-checking bench for ordered_list_engine_unit: directed script, then random bursts.
// A queue-based copy of the list predicts each result word; depends on oled_pkg and the RTL.
`timescale 1ns / 1ps

module ordered_list_engine_unit_tb;
  import oled_pkg::*;

  localparam logic [POS_W-1:0] NO_POS = '1;
  localparam data_t NEG1 = 32'hFFFF_FFFF;
  localparam int SCRIPT_LEN = 22;
  localparam int RANDOM_ITEMS = 1400;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] entry_count;
    data_t            max_v;
    data_t            min_v;
  } list_result_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    data_t           value;
    list_result_t    want;
  } pending_word_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    data_t           value;
    logic            typed;
    list_result_t    want;
  } script_row_t;

  typedef enum {BURST_GROW, BURST_DRAIN, BURST_CHURN} burst_mode_t;

  // Directed script: results typed in where they are obvious, else predicted
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{OP_REMOVE, 32'h0000_0005, 1'b1, '{ST_MISS, NO_POS, 7'd0, NEG1, NEG1}},
    '{OP_LOCATE, 32'h0000_0000, 1'b1, '{ST_MISS, NO_POS, 7'd0, NEG1, NEG1}},
    '{OP_FRONT,  32'h7FFF_FFFF, 1'b1,
      '{ST_OK, NO_POS, 7'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF}},
    '{OP_BACK,   32'h8000_0000, 1'b1,
      '{ST_OK, NO_POS, 7'd2, 32'h7FFF_FFFF, 32'h8000_0000}},
    '{OP_FRONT,  32'hFFFF_FFFF, 1'b0, '0},
    '{OP_LOCATE, 32'h8000_0000, 1'b0, '0},
    '{OP_LOCATE, 32'hFFFF_FFFF, 1'b0, '0},
    '{OP_LOCATE, 32'h1234_5678, 1'b0, '0},
    '{OP_REMOVE, 32'h7FFF_FFFF, 1'b0, '0},
    '{OP_REMOVE, 32'hFFFF_FFFF, 1'b0, '0},
    '{OP_REMOVE, 32'h8000_0000, 1'b1, '{ST_OK, NO_POS, 7'd0, NEG1, NEG1}},
    '{OP_BACK,   32'hFFFF_FFFF, 1'b1, '{ST_OK, NO_POS, 7'd1, NEG1, NEG1}},
    '{OP_BACK,   32'h5555_5555, 1'b0, '0},
    '{OP_FRONT,  32'hAAAA_AAAA, 1'b0, '0},
    '{OP_BACK,   32'hFFFF_FFFF, 1'b0, '0},
    '{OP_LOCATE, 32'hFFFF_FFFF, 1'b0, '0},
    '{OP_REMOVE, 32'hFFFF_FFFF, 1'b0, '0},
    '{OP_LOCATE, 32'hFFFF_FFFF, 1'b0, '0},
    '{OP_REMOVE, 32'h0000_0000, 1'b0, '0},
    '{OP_FRONT,  32'h0000_0000, 1'b0, '0},
    '{OP_LOCATE, 32'h0000_0000, 1'b0, '0},
    '{OP_REMOVE, 32'hFFFF_FFFF, 1'b0, '0}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]        in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [ST_W-1:0]        out_tuser;

  data_t         shadow_list[$];
  pending_word_t pending_results[$];
  int            mismatch_count = 0;
  int            words_sent = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;

  ordered_list_engine_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #2_000_000;
    $display("ordered_list_engine_unit_tb: errors");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
  endtask

  // Apply one operation to the shadow list and work out the result word
  function automatic list_result_t apply_list_op(input logic [OP_W-1:0] op,
                                                 input data_t v);
    list_result_t r;
    int hit;
    hit = -1;
    r.status = ST_OK;
    r.position = NO_POS;
    case (op)
      OP_FRONT, OP_BACK: begin
        if (shadow_list.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (op == OP_FRONT) begin
          shadow_list.push_front(v);
        end else begin
          shadow_list.push_back(v);
        end
      end
      default: begin
        foreach (shadow_list[i]) begin
          if (hit < 0 && shadow_list[i] == v) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_MISS;
        end else if (op == OP_LOCATE) begin
          r.position = POS_W'(hit);
        end else begin
          shadow_list.delete(hit);
        end
      end
    endcase
    r.entry_count = POS_W'(shadow_list.size());
    r.max_v = NEG1;
    r.min_v = NEG1;
    if (shadow_list.size() > 0) begin
      r.max_v = shadow_list[0];
      r.min_v = shadow_list[0];
      foreach (shadow_list[i]) begin
        if ($signed(shadow_list[i]) > $signed(r.max_v)) r.max_v = shadow_list[i];
        if ($signed(shadow_list[i]) < $signed(r.min_v)) r.min_v = shadow_list[i];
      end
    end
    return r;
  endfunction

  // Offer one word after a random gap; record its expected result on acceptance
  task automatic push_word(input logic [OP_W-1:0] op, input data_t v,
                           input logic typed = 1'b0, input list_result_t typed_want = '0);
    int gap;
    pending_word_t rec;
    gap = 0;
    while (gap < 16 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_TDATA_W'(v);
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    rec.op = op;
    rec.value = v;
    rec.want = apply_list_op(op, v);
    if (typed) rec.want = typed_want;
    pending_results.push_back(rec);
    words_sent++;
  endtask

  // Drop valid and hold off until every outstanding result has come back
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic data_t pool_value();
    data_t v;
    case ($urandom_range(0, 4))
      0: v = 32'h0000_0000;
      1: v = 32'h0000_0001;
      2: v = NEG1;
      3: v = 32'h8000_0000;
      default: v = 32'h7FFF_FFFF;
    endcase
    return v;
  endfunction

  // Value mix: mostly held values when hits matter, else extremes or noise
  function automatic data_t pick_value(input int held_pct);
    data_t v;
    int r;
    r = $urandom_range(0, 99);
    if (r < held_pct && shadow_list.size() > 0) begin
      v = shadow_list[$urandom_range(0, shadow_list.size() - 1)];
    end else if (r < held_pct + 15) begin
      v = pool_value();
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  function automatic logic [OP_W-1:0] insert_op();
    return $urandom_range(0, 1) ? OP_BACK : OP_FRONT;
  endfunction

  // One burst of random words shaped by the mode
  task automatic run_burst(input burst_mode_t mode, input int len);
    logic [OP_W-1:0] op;
    int r;
    repeat (len) begin
      r = $urandom_range(0, 99);
      case (mode)
        BURST_GROW:  op = (r < 85) ? insert_op() : (r < 93 ? OP_REMOVE : OP_LOCATE);
        BURST_DRAIN: op = (r < 70) ? OP_REMOVE : (r < 85 ? OP_LOCATE : insert_op());
        default:     op = OP_W'($urandom_range(0, 3));
      endcase
      if (op == OP_REMOVE || op == OP_LOCATE) begin
        push_word(op, pick_value(75));
      end else begin
        push_word(op, pick_value(20));
      end
    end
  endtask

  // Fill past capacity, drain past empty, then random bursts up to the budget
  task automatic run_phase(input int send_pct, input int recv_pct, input int budget);
    int stop_at;
    int len;
    stop_at = words_sent + budget;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    while (shadow_list.size() < CAPACITY) push_word(insert_op(), pick_value(10));
    repeat (3) push_word(insert_op(), pick_value(10));
    while (shadow_list.size() > 0) begin
      push_word(OP_REMOVE, shadow_list[$urandom_range(0, shadow_list.size() - 1)]);
    end
    push_word(OP_REMOVE, $urandom);
    push_word(OP_LOCATE, $urandom);
    while (words_sent < stop_at) begin
      len = $urandom_range(20, 120);
      if (len > stop_at - words_sent) len = stop_at - words_sent;
      run_burst(burst_mode_t'($urandom_range(0, 2)), len);
      if ($urandom_range(0, 3) == 0) wait_for_results();
    end
    wait_for_results();
  endtask

  // Result side: random back-pressure, check each accepted word in order
  initial begin
    pending_word_t exp_word;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid === 1'b1 && out_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result word with nothing outstanding", out_tdata[31:0], '0);
        end else begin
          exp_word = pending_results.pop_front();
          if (out_tuser !== exp_word.want.status)
            report_mismatch($sformatf("status, op %0d value %h", exp_word.op,
                                      exp_word.value), 32'(out_tuser),
                            32'(exp_word.want.status));
          if (out_tdata[6:0] !== exp_word.want.position)
            report_mismatch($sformatf("position, op %0d value %h", exp_word.op,
                                      exp_word.value), 32'(out_tdata[6:0]),
                            32'(exp_word.want.position));
          if (out_tdata[13:7] !== exp_word.want.entry_count)
            report_mismatch($sformatf("entry_count, op %0d value %h", exp_word.op,
                                      exp_word.value), 32'(out_tdata[13:7]),
                            32'(exp_word.want.entry_count));
          if (out_tdata[45:14] !== exp_word.want.max_v)
            report_mismatch($sformatf("max_value, op %0d value %h", exp_word.op,
                                      exp_word.value), out_tdata[45:14], exp_word.want.max_v);
          if (out_tdata[77:46] !== exp_word.want.min_v)
            report_mismatch($sformatf("min_value, op %0d value %h", exp_word.op,
                                      exp_word.value), out_tdata[77:46], exp_word.want.min_v);
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Stimulus and verdict
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed script with light back-pressure
    recv_stall_pct = 20;
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      push_word(SCRIPT[i].op, SCRIPT[i].value, SCRIPT[i].typed, SCRIPT[i].want);
    end
    wait_for_results();

    run_phase(24, 51, RANDOM_ITEMS / 3);
    run_phase(51, 24, RANDOM_ITEMS / 3);
    run_phase(0, 0, RANDOM_ITEMS / 3);

    // Let any stray word show up before the verdict
    repeat (CAPACITY + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ordered_list_engine_unit_tb: clean");
    end else begin
      $display("ordered_list_engine_unit_tb: errors");
    end
    $finish;
  end

endmodule
